// ===== design/psrg_pkg.sv =====
// ----------------------------------------------------------------------------
// psrg_pkg: shared types and constants for the pixel sample resolver
// Field widths, root pipeline widths, queue depth and register map.
// ----------------------------------------------------------------------------
package psrg_pkg;

	localparam int SUM_W                 = 26;
	localparam int SPP_W                 = 11;
	localparam int LEVEL_W               = 8;
	localparam int ROOT_STEPS            = LEVEL_W;
	localparam int RN_W                  = LEVEL_W + SPP_W;
	localparam int P_W                   = 2 * LEVEL_W + SPP_W;
	localparam int Q_SCALE_BITS          = 16;
	localparam int DEFAULT_FRACTION_BITS = 16;
	localparam int QUEUE_DEPTH           = 4;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic             REG_SPP_IDX = 1'b0;
	localparam logic [SPP_W-1:0] SPP_RESET   = SPP_W'(1);

	typedef logic [SUM_W-1:0] sum_t;

	typedef struct packed {
		sum_t             sum_red;
		sum_t             sum_green;
		sum_t             sum_blue;
		logic [SPP_W-1:0] n;
	} item_t;

	// running state of one channel's digit-by-digit root: r, r*n and r*r*n
	typedef struct packed {
		sum_t               sum;
		logic [LEVEL_W-1:0] r;
		logic [RN_W-1:0]    rn;
		logic [P_W-1:0]     p;
	} root_chan_t;

	typedef struct packed {
		root_chan_t [2:0] ch;
		logic [SPP_W-1:0] n;
	} root_stage_t;

endpackage

// ===== design/psrg_if.sv =====
// ----------------------------------------------------------------------------
// psrg_if: stream channels of the pixel sample resolver
// Pixel sums in, quantized levels out, each with valid/ready.
// ----------------------------------------------------------------------------
interface psrg_pixel_if
	import psrg_pkg::*;
();
	logic valid;
	logic ready;
	sum_t sum_red;
	sum_t sum_green;
	sum_t sum_blue;

	modport source (output valid, output sum_red, output sum_green, output sum_blue,
		input ready);
	modport sink (input valid, input sum_red, input sum_green, input sum_blue,
		output ready);
endinterface

interface psrg_level_if
	import psrg_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] red_level;
	logic [LEVEL_W-1:0] green_level;
	logic [LEVEL_W-1:0] blue_level;

	modport source (output valid, output red_level, output green_level,
		output blue_level, input ready);
	modport sink (input valid, input red_level, input green_level, input blue_level,
		output ready);
endinterface

// ===== design/psrg_front.sv =====
// ----------------------------------------------------------------------------
// psrg_front: input stage
// Registers each pixel beat together with its effective sample count.
// ----------------------------------------------------------------------------
module psrg_front
	import psrg_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [SPP_W-1:0] spp,
	psrg_pixel_if.sink       pixel,
	output logic             out_valid,
	input  logic             out_ready,
	output item_t            out_item
);

	logic  valid_s1;
	item_t item_s1;
	logic  take;

	assign pixel.ready = !valid_s1 || out_ready;
	assign take        = pixel.valid && pixel.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixel.ready) begin
			valid_s1 <= pixel.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.sum_red   <= pixel.sum_red;
			item_s1.sum_green <= pixel.sum_green;
			item_s1.sum_blue  <= pixel.sum_blue;
			// a zero count divides as one
			item_s1.n         <= (spp == '0) ? SPP_W'(1) : spp;
		end
	end

	assign out_valid = valid_s1;
	assign out_item  = item_s1;

endmodule

// ===== design/psrg_queue.sv =====
// ----------------------------------------------------------------------------
// psrg_queue: short FIFO between front and back
// Lets the input side keep taking beats while the root pipeline stalls.
// ----------------------------------------------------------------------------
module psrg_queue
	import psrg_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  item_t push_item,
	output logic  pop_valid,
	input  logic  pop_ready,
	output item_t pop_item
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)      count_q <= count_q + CNT_W'(1);
			else if (pop && !push) count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_item;
	end

endmodule

// ===== design/psrg_back.sv =====
// ----------------------------------------------------------------------------
// psrg_back: root pipeline
// One root bit per stage, three channels in parallel. A bit is kept when
// (r+b)^2 * n * 2^F <= sum * 2^16, which folds the average into the root.
// ----------------------------------------------------------------------------
module psrg_back
	import psrg_pkg::*;
#(
	parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  item_t       in_item,
	psrg_level_if.source level
);

	localparam int LHS_W = P_W + FRACTION_BITS;
	localparam int RHS_W = SUM_W + Q_SCALE_BITS;
	localparam int CMP_W = (LHS_W > RHS_W) ? LHS_W : RHS_W;
	localparam int LAST  = ROOT_STEPS - 1;

	function automatic root_chan_t root_step(root_chan_t c, logic [SPP_W-1:0] n,
		int unsigned b);
		logic [RN_W-1:0]  cand_rn;
		logic [P_W-1:0]   cand_p;
		logic [CMP_W-1:0] lhs;
		logic [CMP_W-1:0] rhs;
		root_chan_t       o;
		// (r+b)^2 n = r^2 n + 2 b r n + b^2 n, all by shifts
		cand_rn = c.rn + (RN_W'(n) << b);
		cand_p  = c.p + (P_W'(c.rn) << (b + 1)) + (P_W'(n) << (2 * b));
		lhs     = CMP_W'(cand_p);
		lhs     = lhs << FRACTION_BITS;
		rhs     = CMP_W'(c.sum);
		rhs     = rhs << Q_SCALE_BITS;
		o       = c;
		if (lhs <= rhs) begin
			o.r  = c.r | (LEVEL_W'(1) << b);
			o.rn = cand_rn;
			o.p  = cand_p;
		end
		return o;
	endfunction

	root_stage_t stage_s [ROOT_STEPS];
	logic        valid_s [ROOT_STEPS];
	logic        adv     [ROOT_STEPS];
	root_stage_t init;

	always_comb begin
		init.n = in_item.n;
		init.ch[0] = '{sum: in_item.sum_red,   r: '0, rn: '0, p: '0};
		init.ch[1] = '{sum: in_item.sum_green, r: '0, rn: '0, p: '0};
		init.ch[2] = '{sum: in_item.sum_blue,  r: '0, rn: '0, p: '0};
	end

	for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_stage
		root_stage_t src;
		root_stage_t nxt;
		logic        src_valid;

		if (k == 0) begin : g_head
			assign src       = init;
			assign src_valid = in_valid;
		end else begin : g_body
			assign src       = stage_s[k-1];
			assign src_valid = valid_s[k-1];
		end

		if (k == LAST) begin : g_tail
			assign adv[k] = !valid_s[k] || level.ready;
		end else begin : g_mid
			assign adv[k] = !valid_s[k] || adv[k+1];
		end

		always_comb begin
			nxt.n = src.n;
			for (int c = 0; c < 3; c++) begin
				nxt.ch[c] = root_step(src.ch[c], src.n, ROOT_STEPS - 1 - k);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (adv[k]) begin
				valid_s[k] <= src_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (adv[k] && src_valid) stage_s[k] <= nxt;
		end
	end

	assign in_ready          = adv[0];
	assign level.valid       = valid_s[LAST];
	assign level.red_level   = stage_s[LAST].ch[0].r;
	assign level.green_level = stage_s[LAST].ch[1].r;
	assign level.blue_level  = stage_s[LAST].ch[2].r;

endmodule

// ===== design/pixel_sample_resolve_gamma2.sv =====
// ----------------------------------------------------------------------------
// pixel_sample_resolve_gamma2: resolve accumulated samples to 8-bit levels
// Averages each channel sum over the sample count, takes the gamma 2 root
// and quantizes to 0..255, saturating at 255 for averages of 1.0 or more.
//
// pixel: sink of valid/ready beats with the red, green and blue sums.
// level: source of valid/ready beats with the three 8-bit levels, one per
//        pixel, in input order.
// APB:   samples_per_pixel at byte address 0 (reset value 1, zero acts as 1).
//        Write it only while no pixel is in flight. pready is always high.
// Throughput is one pixel per clock while the receiver is ready: an input
// register, a four-entry queue and an eight-stage root pipeline, one result
// bit per stage, all advance every cycle unless stalled. When the receiver
// stalls the pipeline holds in place and fills its bubbles, then the queue
// fills, and pixel.ready drops only once the input register is full too.
// Reset empties the pipeline and queue and restores the count to 1.
// ----------------------------------------------------------------------------
module pixel_sample_resolve_gamma2
	import psrg_pkg::*;
#(
	parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	psrg_pixel_if.sink            pixel,
	psrg_level_if.source          level
);

	logic [SPP_W-1:0] spp_q;
	logic             cfg_wr;
	logic             reg_idx;

	logic  fq_valid;
	logic  fq_ready;
	item_t fq_item;
	logic  qb_valid;
	logic  qb_ready;
	item_t qb_item;

	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_ADDR_W-1];
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign prdata  = (reg_idx == REG_SPP_IDX) ? APB_DATA_W'(spp_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spp_q <= SPP_RESET;
		end else if (cfg_wr && reg_idx == REG_SPP_IDX) begin
			spp_q <= pwdata[SPP_W-1:0];
		end
	end

	psrg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.spp       (spp_q),
		.pixel     (pixel),
		.out_valid (fq_valid),
		.out_ready (fq_ready),
		.out_item  (fq_item)
	);

	psrg_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_item  (fq_item),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_item   (qb_item)
	);

	psrg_back #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (qb_valid),
		.in_ready (qb_ready),
		.in_item  (qb_item),
		.level    (level)
	);

	// a divisor of zero never reaches the root pipeline
	a_n_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		fq_valid |-> fq_item.n != '0)
		else $error("zero sample count entered the queue");

	// a taken pixel shows up at the queue input on the next cycle
	a_front_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel.valid && pixel.ready) |=> fq_valid)
		else $error("accepted pixel lost in front stage");

	// a stalled queue head holds its item
	a_queue_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(qb_valid && !qb_ready) |=> (qb_valid && $stable(qb_item)))
		else $error("queue head changed while stalled");

endmodule
